@@ src/ssmp_pkg.sv @@
// shared types, constants and codes for the sorted store with median pop
`timescale 1ns / 1ps
`default_nettype none
package ssmp_pkg;

	localparam int DEPTH  = 64;
	localparam int DATA_W = 32;
	localparam int FILL_W = 7;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int GRP    = 8;
	localparam int NGRP   = (DEPTH + GRP - 1) / GRP;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_POP    = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic                     op;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] median;
		status_t                  status;
		logic [FILL_W-1:0]        fill;
	} rsp_t;

	// broadcast from the top level to every cell
	typedef struct packed {
		logic                     ins_en;
		logic                     pop_en;
		logic signed [DATA_W-1:0] value;
		logic [CNT_W-1:0]         count;
		logic [IDX_W-1:0]         med_idx;
	} cell_ctl_t;

endpackage
`default_nettype wire

@@ src/ssmp_cell.sv @@
// one storage cell of the sorted chain: compare, shift up on insert, shift down on pop
`timescale 1ns / 1ps
`default_nettype none
module ssmp_cell (
	input  wire logic                              clk,
	input  wire ssmp_pkg::cell_ctl_t               ctl,
	input  wire logic [ssmp_pkg::IDX_W-1:0]        idx,
	input  wire logic                              prev_cmp,
	input  wire logic signed [ssmp_pkg::DATA_W-1:0] prev_entry,
	input  wire logic signed [ssmp_pkg::DATA_W-1:0] next_entry,
	output logic signed [ssmp_pkg::DATA_W-1:0]     entry,
	output logic                                   cmp,
	output logic                                   sel,
	output logic signed [ssmp_pkg::DATA_W-1:0]     sel_val
);
	import ssmp_pkg::*;

	logic signed [DATA_W-1:0] entry_q;
	logic signed [DATA_W-1:0] entry_d;

	// entry stays in place while it is held and smaller than the new value
	assign cmp     = (CNT_W'(idx) < ctl.count) && (entry_q < ctl.value);
	assign sel     = ctl.pop_en && (idx == ctl.med_idx);
	assign sel_val = sel ? entry_q : '0;
	assign entry   = entry_q;

	always_comb begin
		entry_d = entry_q;
		if (ctl.ins_en) begin
			if (!cmp) begin
				entry_d = prev_cmp ? ctl.value : prev_entry;
			end
		end else if (ctl.pop_en) begin
			if (idx >= ctl.med_idx) begin
				entry_d = next_entry;
			end
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= entry_d;
	end

endmodule
`default_nettype wire

@@ src/sorted_store_median_pop.sv @@
// top level: sorted store of signed values with lower-median pop
//
// usage
//   req channel (req_valid / req_ready / req) carries one transaction per item:
//   op selects insert (value goes into sorted position) or pop (lower median
//   removed). rsp channel (rsp_valid / rsp_ready / rsp) returns exactly one
//   transaction per item with median, status and fill.
// structure
//   a row of DEPTH cells, each holding one entry. every cell compares its entry
//   with the broadcast value and takes its own, its lower neighbor's or the new
//   value on an insert, or its own or its upper neighbor's on a pop, so either
//   completes in its accept cycle. the popped entry is gathered by a two-level or
//   tree (groups of eight, registered), then lands in the output register.
// timing
//   one item per cycle sustained while rsp_ready is high; the response passes
//   through the gather stage, then the output register.
// reset
//   arst_n clears the entry count and all valid flags; stored values are not
//   cleared and are never read before they are written.
// stall
//   while rsp_ready is low the output register holds; one more item is taken
//   into the gather stage, then req_ready drops until the output drains.
`timescale 1ns / 1ps
`default_nettype none
module sorted_store_median_pop (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire ssmp_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output ssmp_pkg::rsp_t      rsp
);
	import ssmp_pkg::*;

	// entry count and its derived flags
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic [CNT_W-1:0] count_m1;
	logic             full;
	logic             empty;
	logic             accept;

	// cell row wiring
	cell_ctl_t                ctl;
	logic signed [DATA_W-1:0] cell_entry [DEPTH];
	logic signed [DATA_W-1:0] cell_sel   [DEPTH];
	logic [DEPTH-1:0]         cell_cmp;
	logic [DEPTH-1:0]         sel_vec;

	// gather stage and output register
	logic                     valid_s1;
	logic signed [DATA_W-1:0] grp_d  [NGRP];
	logic signed [DATA_W-1:0] grp_s1 [NGRP];
	status_t                  status_d;
	status_t                  status_s1;
	logic [FILL_W-1:0]        fill_s1;
	logic                     advance;
	logic signed [DATA_W-1:0] median_d;
	logic                     rsp_valid_q;
	rsp_t                     rsp_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign count_m1 = count_q - CNT_W'(1);

	// output register frees when empty or taken; gather stage moves with it
	assign advance   = !rsp_valid_q || rsp_ready;
	assign req_ready = !valid_s1 || advance;
	assign accept    = req_valid && req_ready;

	// broadcast control to the row
	always_comb begin
		ctl.ins_en  = accept && (req.op == OP_INSERT) && !full;
		ctl.pop_en  = accept && (req.op == OP_POP) && !empty;
		ctl.value   = req.value;
		ctl.count   = count_q;
		ctl.med_idx = IDX_W'(count_m1 >> 1);
	end

	always_comb begin
		count_d  = count_q;
		status_d = ST_OK;
		if (req.op == OP_INSERT) begin
			if (full) begin
				status_d = ST_FULL;
			end else begin
				count_d = count_q + CNT_W'(1);
			end
		end else begin
			if (empty) begin
				status_d = ST_EMPTY;
			end else begin
				count_d = count_m1;
			end
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic                     p_cmp;
			logic signed [DATA_W-1:0] p_entry;
			logic signed [DATA_W-1:0] n_entry;

			// bottom cell always sees a "smaller" neighbor below it
			if (gi == 0) begin : g_bot
				assign p_cmp   = 1'b1;
				assign p_entry = cell_entry[gi];
			end else begin : g_mid
				assign p_cmp   = cell_cmp[gi-1];
				assign p_entry = cell_entry[gi-1];
			end
			// top cell has nothing above; its value is past the count after a pop
			if (gi == DEPTH - 1) begin : g_top
				assign n_entry = cell_entry[gi];
			end else begin : g_low
				assign n_entry = cell_entry[gi+1];
			end

			ssmp_cell u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.idx        (IDX_W'(gi)),
				.prev_cmp   (p_cmp),
				.prev_entry (p_entry),
				.next_entry (n_entry),
				.entry      (cell_entry[gi]),
				.cmp        (cell_cmp[gi]),
				.sel        (sel_vec[gi]),
				.sel_val    (cell_sel[gi])
			);
		end
	endgenerate

	// first level of the gather tree: or within each group of eight cells
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < GRP; k++) begin
				if (g * GRP + k < DEPTH) begin
					grp_d[g] = grp_d[g] | cell_sel[g * GRP + k];
				end
			end
		end
	end

	// second level: or across the registered groups
	always_comb begin
		median_d = '0;
		for (int g = 0; g < NGRP; g++) begin
			median_d = median_d | grp_s1[g];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= count_d;
			end
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				rsp_valid_q <= valid_s1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			grp_s1    <= grp_d;
			status_s1 <= status_d;
			fill_s1   <= FILL_W'(count_d);
		end
		if (advance && valid_s1) begin
			rsp_q.median <= median_d;
			rsp_q.status <= status_s1;
			rsp_q.fill   <= fill_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// count never passes the store size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");

	// an accepted insert into a store with room grows the count by one
	a_insert_grow: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.op == OP_INSERT) && !full |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not grow count");

	// an accepted pop on a non-empty store shrinks the count by one
	a_pop_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (req.op == OP_POP) && !empty |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("pop did not shrink count");

	// at most one cell hands out its entry on a pop
	a_one_sel: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(sel_vec))
		else $error("several cells selected as median");

	// a full gather stage holds while the output register is stalled
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && rsp_valid_q && !rsp_ready |=> valid_s1 && $stable(status_s1))
		else $error("gather stage overwritten while stalled");

endmodule
`default_nettype wire
